/* rtl/core/ptrs_pkg.sv */
// shared types and constants for the pan/tilt raster scan sequencer
package ptrs_pkg;

    localparam int FRAME_BYTES = 11;
    localparam int LEN_W       = 4;

    localparam logic [7:0] SYNC_SERVO = 8'hFF;
    localparam logic [7:0] SYNC_HOST  = 8'hF5;
    localparam logic [7:0] ID_PAN     = 8'd1;
    localparam logic [7:0] ID_TILT    = 8'd2;
    localparam logic [7:0] STEP_SIZE  = 8'd4;

    localparam logic [LEN_W-1:0] LEN_NONE   = 4'd0;
    localparam logic [LEN_W-1:0] LEN_PAN    = 4'd3;
    localparam logic [LEN_W-1:0] LEN_TILT   = 4'd6;
    localparam logic [LEN_W-1:0] LEN_REPORT = 4'd11;

    localparam logic [7:0] PAN_START_RST  = 8'd228;
    localparam logic [7:0] PAN_END_RST    = 8'd36;
    localparam logic [7:0] TILT_START_RST = 8'd131;
    localparam logic [7:0] TILT_END_RST   = 8'd245;

    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_REPORT  = 1'b1;

    localparam logic LINK_SERVO = 1'b0;
    localparam logic LINK_HOST  = 1'b1;

    typedef enum logic [1:0] {
        REG_PAN_START  = 2'd0,
        REG_PAN_END    = 2'd1,
        REG_TILT_START = 2'd2,
        REG_TILT_END   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic                              link;
        logic [LEN_W-1:0]                  len;
        logic [FRAME_BYTES-1:0][7:0]       bytes;
    } frame_t;

endpackage

/* rtl/core/ptrs_if.sv */
// valid/ready channel interfaces for scan items and output bytes
interface ptrs_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] adc_sample;
    logic [15:0] echo_time;

    modport source (output valid, output op, output adc_sample, output echo_time,
                    input ready);
    modport sink   (input valid, input op, input adc_sample, input echo_time,
                    output ready);
endinterface

interface ptrs_out_if;
    logic       valid;
    logic       ready;
    logic       link;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output link, output data_byte, output last,
                    input ready);
    modport sink   (input valid, input link, input data_byte, input last,
                    output ready);
endinterface

/* rtl/core/ptrs_emit.sv */
// pending frame buffer and byte serializer for the output channel
module ptrs_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  ptrs_pkg::frame_t frame,
    output logic             free,
    ptrs_out_if.source       out_ch
);
    import ptrs_pkg::*;

    frame_t                      pend_reg;
    logic                        pend_valid_reg, pend_valid_next;
    logic [FRAME_BYTES-1:0][7:0] buf_reg, buf_next;
    logic                        link_reg, link_next;
    logic [LEN_W-1:0]            rem_reg, rem_next;
    logic                        xfer;
    logic                        load;

    assign xfer = out_ch.valid && out_ch.ready;
    // take the pending frame when the serializer is empty or drains its last byte
    assign load = pend_valid_reg && ((rem_reg == LEN_NONE) || (rem_reg == 4'd1 && xfer));
    assign free = !pend_valid_reg || load;

    assign out_ch.valid     = (rem_reg != LEN_NONE);
    assign out_ch.link      = link_reg;
    assign out_ch.data_byte = buf_reg[0];
    assign out_ch.last      = (rem_reg == 4'd1);

    always_comb
    begin
        buf_next        = buf_reg;
        link_next       = link_reg;
        rem_next        = rem_reg;
        pend_valid_next = pend_valid_reg;
        if (load)
        begin
            buf_next        = pend_reg.bytes;
            link_next       = pend_reg.link;
            rem_next        = pend_reg.len;
            pend_valid_next = 1'b0;
        end
        else if (xfer)
        begin
            buf_next = {8'h00, buf_reg[FRAME_BYTES-1:1]};
            rem_next = rem_reg - 4'd1;
        end
        if (wr)
        begin
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            rem_reg        <= LEN_NONE;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            rem_reg        <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        link_reg <= link_next;
        if (wr)
        begin
            pend_reg <= frame;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && !load) |-> !wr)
        else $error("pending frame overwritten before it was taken");

    a_load_len: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (rem_reg == $past(pend_reg.len)))
        else $error("serializer count does not match loaded frame");

    a_pend_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (pend_reg.len != LEN_NONE))
        else $error("empty frame held as pending");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= LEN_REPORT)
        else $error("byte count beyond frame size");
`endif

endmodule

/* rtl/core/pan_tilt_raster_scan_sequencer.sv */
// top level of the pan/tilt raster scan sequencer
//
//  channel | dir | payload                         | transfer
//  in_ch   | in  | op, adc_sample, echo_time       | valid && ready
//  out_ch  | out | link, data_byte, last           | valid && ready
//  apb     | in  | paddr[3:0], pwdata/prdata 32b   | psel && penable && pwrite
//
// when an item is taken, positions update and its whole frame is
// registered as pending at that edge; bytes then leave one per cycle
// (11 for a report, 6 or 3 for an advance, none when halted) while
// out_ch.ready is high, so the sustained rate is set by the output serializer.
// in_ch.ready stays high while the pending slot is free or drains this cycle.
// reset loads the register reset values and the start positions from them.
module pan_tilt_raster_scan_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ptrs_in_if.sink     in_ch,
    ptrs_out_if.source  out_ch
);
    import ptrs_pkg::*;

    logic [7:0] pan_start_reg, pan_end_reg, tilt_start_reg, tilt_end_reg;
    logic [7:0] pan_pos_reg, pan_pos_next;
    logic [7:0] tilt_pos_reg, tilt_pos_next;
    logic       sweep_up_reg, sweep_up_next;
    logic       tilt_done_reg, tilt_done_next;
    logic       halted_reg, halted_next;

    reg_idx_t   cfg_idx;
    logic       cfg_wr;
    logic       in_xfer;
    logic       emit_free;
    frame_t     frame;

    logic [8:0] pan_dn;
    logic [8:0] pan_up;
    logic [8:0] tilt_up;
    logic       turn;
    logic [7:0] pan_new;
    logic [7:0] tilt_new;
    logic       tilt_hit;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        case (cfg_idx)
            REG_PAN_START:  prdata = {24'h0, pan_start_reg};
            REG_PAN_END:    prdata = {24'h0, pan_end_reg};
            REG_TILT_START: prdata = {24'h0, tilt_start_reg};
            REG_TILT_END:   prdata = {24'h0, tilt_end_reg};
            default:        prdata = 32'h0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_start_reg  <= PAN_START_RST;
            pan_end_reg    <= PAN_END_RST;
            tilt_start_reg <= TILT_START_RST;
            tilt_end_reg   <= TILT_END_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_PAN_START:  pan_start_reg  <= pwdata[7:0];
                REG_PAN_END:    pan_end_reg    <= pwdata[7:0];
                REG_TILT_START: tilt_start_reg <= pwdata[7:0];
                REG_TILT_END:   tilt_end_reg   <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    // scan step
    assign in_xfer = in_ch.valid && in_ch.ready;
    assign in_ch.ready = emit_free;

    assign pan_dn  = {1'b0, pan_pos_reg} - {1'b0, STEP_SIZE};
    assign pan_up  = {1'b0, pan_pos_reg} + {1'b0, STEP_SIZE};
    assign tilt_up = {1'b0, tilt_pos_reg} + {1'b0, STEP_SIZE};

    always_comb
    begin
        if (!sweep_up_reg)
        begin
            // a borrow means the step went below zero, so past the end too
            turn = (pan_pos_reg <= pan_end_reg) || pan_dn[8] || (pan_dn[7:0] <= pan_end_reg);
            pan_new = turn ? pan_end_reg : pan_dn[7:0];
        end
        else
        begin
            turn = (pan_pos_reg >= pan_start_reg) || (pan_up >= {1'b0, pan_start_reg});
            pan_new = turn ? pan_start_reg : pan_up[7:0];
        end
        tilt_hit = (tilt_pos_reg >= tilt_end_reg) || (tilt_up >= {1'b0, tilt_end_reg});
        tilt_new = tilt_hit ? tilt_end_reg : tilt_up[7:0];
    end

    always_comb
    begin
        pan_pos_next   = pan_pos_reg;
        tilt_pos_next  = tilt_pos_reg;
        sweep_up_next  = sweep_up_reg;
        tilt_done_next = tilt_done_reg;
        halted_next    = halted_reg;
        if (in_xfer && in_ch.op == OP_ADVANCE && !halted_reg)
        begin
            pan_pos_next = pan_new;
            if (turn)
            begin
                sweep_up_next = !sweep_up_reg;
                tilt_pos_next = tilt_new;
                if (tilt_hit)
                begin
                    tilt_done_next = 1'b1;
                end
            end
            if (tilt_done_reg)
            begin
                halted_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_pos_reg   <= PAN_START_RST;
            tilt_pos_reg  <= TILT_START_RST;
            sweep_up_reg  <= 1'b0;
            tilt_done_reg <= 1'b0;
            halted_reg    <= 1'b0;
        end
        else
        begin
            pan_pos_reg   <= pan_pos_next;
            tilt_pos_reg  <= tilt_pos_next;
            sweep_up_reg  <= sweep_up_next;
            tilt_done_reg <= tilt_done_next;
            halted_reg    <= halted_next;
        end
    end

    // frame assembly
    always_comb
    begin
        frame.bytes = '0;
        if (in_ch.op == OP_REPORT)
        begin
            frame.link      = LINK_HOST;
            frame.len       = LEN_REPORT;
            frame.bytes[0]  = SYNC_HOST;
            frame.bytes[1]  = {3'b000, in_ch.adc_sample[15:11]};
            frame.bytes[2]  = {1'b0, in_ch.adc_sample[10:4]};
            frame.bytes[3]  = {7'h00, in_ch.echo_time[15]};
            frame.bytes[4]  = {1'b0, in_ch.echo_time[14:8]};
            frame.bytes[5]  = {7'h00, in_ch.echo_time[7]};
            frame.bytes[6]  = {1'b0, in_ch.echo_time[6:0]};
            frame.bytes[7]  = {7'h00, pan_pos_reg[7]};
            frame.bytes[8]  = {1'b0, pan_pos_reg[6:0]};
            frame.bytes[9]  = {7'h00, tilt_pos_reg[7]};
            frame.bytes[10] = {1'b0, tilt_pos_reg[6:0]};
        end
        else
        begin
            frame.link     = LINK_SERVO;
            frame.len      = halted_reg ? LEN_NONE : (turn ? LEN_TILT : LEN_PAN);
            frame.bytes[0] = SYNC_SERVO;
            frame.bytes[1] = ID_PAN;
            frame.bytes[2] = pan_new;
            frame.bytes[3] = SYNC_SERVO;
            frame.bytes[4] = ID_TILT;
            frame.bytes[5] = tilt_new;
        end
    end

    ptrs_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (in_xfer && (frame.len != LEN_NONE)),
        .frame  (frame),
        .free   (emit_free),
        .out_ch (out_ch)
    );

`ifndef NO_ASSERTIONS
    a_halt_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> tilt_done_reg)
        else $error("halted without tilt finished");

    a_halt_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> ($stable(pan_pos_reg) && $stable(tilt_pos_reg)))
        else $error("positions moved while halted");

    a_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tilt_done_reg) |-> (tilt_pos_reg == $past(tilt_end_reg)))
        else $error("tilt finished away from its end");
`endif

endmodule
